FILE: rtl/mse_pkg.sv
// Package: shared constants, state and command types for the merge sort engine.
`timescale 1ns / 1ps
`default_nettype none
package mse_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_RUN,
    S_RD,
    S_WR,
    S_OUT_RD,
    S_OUT_SHOW
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RUN_INIT,
    OP_RD,
    OP_WR,
    OP_RUN_NEXT,
    OP_PASS_NEXT,
    OP_OUT_START,
    OP_OUT_RD,
    OP_OUT_POP
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic pass_done;  // run width has reached the element count
    logic run_done;   // all runs of the current pass are merged
    logic elem_done;  // current run pair fully written
    logic out_last;   // element under output index is the final one
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/merge_sort_engine.sv
// Flow: items are stored while in_ready is high; after the last item, the engine runs
// ceil(log2 n) merge passes over the n stored values, then a final pass check sees the
// end; each compare follows a registered memory read, then compares and writes.
// Output: each result is read from the store, then shown until out_ready takes it.
// Throughput: one set at a time; a new set is taken only after the final result is taken.
// Reset: rst_n synchronous, active low; clears count, drop flag and controller only.
`timescale 1ns / 1ps
`default_nettype none
module merge_sort_engine (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel: one value per transaction, last closes the set
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire signed [mse_pkg::DATA_W-1:0]  in_value,
  input  wire                               in_last,
  // result channel: sorted values, ascending
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [mse_pkg::DATA_W-1:0] out_value_res,
  output logic                              out_last_res,
  output logic                              out_dropped
);

  mse_pkg::dp_cmd_t    cmd;
  mse_pkg::dp_status_t status;

  // Controller walks LOAD -> passes of runs -> element merges -> output.
  mse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // Datapath ping-pongs between two stores; the result is read from
  // whichever store the final pass wrote, so no copy-back is needed.
  mse_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_value),
    .status        (status),
    .out_value_res (out_value_res),
    .out_last_res  (out_last_res),
    .out_dropped   (out_dropped)
  );

endmodule
`default_nettype wire

FILE: rtl/mse_ctrl.sv
// Controller: sequences load, merge passes and result output.
`timescale 1ns / 1ps
`default_nettype none
module mse_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_last,
  input  wire                  out_ready,
  input  mse_pkg::dp_status_t  status,
  output mse_pkg::dp_cmd_t     cmd,
  output logic                 in_ready,
  output logic                 out_valid
);

  mse_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mse_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mse_pkg::S_LOAD: begin
        if (in_valid && in_last) state_nxt = mse_pkg::S_PASS;
      end
      mse_pkg::S_PASS: begin
        state_nxt = status.pass_done ? mse_pkg::S_OUT_RD : mse_pkg::S_RUN;
      end
      mse_pkg::S_RUN: begin
        state_nxt = status.run_done ? mse_pkg::S_PASS : mse_pkg::S_RD;
      end
      mse_pkg::S_RD: begin
        state_nxt = status.elem_done ? mse_pkg::S_RUN : mse_pkg::S_WR;
      end
      mse_pkg::S_WR: begin
        state_nxt = mse_pkg::S_RD;
      end
      mse_pkg::S_OUT_RD: begin
        state_nxt = mse_pkg::S_OUT_SHOW;
      end
      mse_pkg::S_OUT_SHOW: begin
        if (out_ready) begin
          state_nxt = status.out_last ? mse_pkg::S_LOAD : mse_pkg::S_OUT_RD;
        end
      end
      default: begin
        state_nxt = mse_pkg::S_LOAD;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd.op    = mse_pkg::OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      mse_pkg::S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = mse_pkg::OP_LOAD;
      end
      mse_pkg::S_PASS: begin
        cmd.op = status.pass_done ? mse_pkg::OP_OUT_START : mse_pkg::OP_NONE;
      end
      mse_pkg::S_RUN: begin
        cmd.op = status.run_done ? mse_pkg::OP_PASS_NEXT : mse_pkg::OP_RUN_INIT;
      end
      mse_pkg::S_RD: begin
        cmd.op = status.elem_done ? mse_pkg::OP_RUN_NEXT : mse_pkg::OP_RD;
      end
      mse_pkg::S_WR: begin
        cmd.op = mse_pkg::OP_WR;
      end
      mse_pkg::S_OUT_RD: begin
        cmd.op = mse_pkg::OP_OUT_RD;
      end
      mse_pkg::S_OUT_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) cmd.op = mse_pkg::OP_OUT_POP;
      end
      default: begin
        cmd.op = mse_pkg::OP_NONE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/mse_datapath.sv
// Datapath: ping-pong stores, merge indexes, compare and output registers.
`timescale 1ns / 1ps
`default_nettype none
module mse_datapath (
  input  wire                               clk,
  input  wire                               rst_n,
  input  mse_pkg::dp_cmd_t                  cmd,
  input  wire signed [mse_pkg::DATA_W-1:0]  in_value,
  output mse_pkg::dp_status_t               status,
  output logic signed [mse_pkg::DATA_W-1:0] out_value_res,
  output logic                              out_last_res,
  output logic                              out_dropped
);

  localparam int DW = mse_pkg::DATA_W;
  localparam int CW = mse_pkg::CNT_W;
  localparam int IW = mse_pkg::IDX_W;

  logic [DW-1:0] mem_a [mse_pkg::DEPTH];
  logic [DW-1:0] mem_b [mse_pkg::DEPTH];
  logic [DW-1:0] a_rd0_r, a_rd1_r, b_rd0_r, b_rd1_r;

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          src_b_r, src_b_nxt;  // 1: sorted runs currently live in store B

  logic [CW:0]   mid_sum, hi_sum;
  logic [CW-1:0] mid_clip, hi_clip;
  logic [DW-1:0] left_v, right_v, merged;
  logic          take_left, has_room, re;
  logic          we_a, we_b;
  logic [IW-1:0] waddr, raddr0, raddr1;
  logic [DW-1:0] wdata;

  assign has_room = count_r < CW'(mse_pkg::DEPTH);

  assign mid_sum  = {1'b0, lo_r} + {1'b0, width_r};
  assign hi_sum   = {1'b0, lo_r} + {width_r, 1'b0};
  assign mid_clip = (mid_sum > {1'b0, count_r}) ? count_r : mid_sum[CW-1:0];
  assign hi_clip  = (hi_sum  > {1'b0, count_r}) ? count_r : hi_sum[CW-1:0];

  assign left_v  = src_b_r ? b_rd0_r : a_rd0_r;
  assign right_v = src_b_r ? b_rd1_r : a_rd1_r;

  // exhaustion flags replace sentinels; ties take the left run (stable)
  always_comb begin
    if (i_r >= mid_r) begin
      take_left = 1'b0;
    end else if (j_r >= hi_r) begin
      take_left = 1'b1;
    end else begin
      take_left = $signed(left_v) <= $signed(right_v);
    end
  end
  assign merged = take_left ? left_v : right_v;

  assign re     = (cmd.op == mse_pkg::OP_RD) || (cmd.op == mse_pkg::OP_OUT_RD);
  assign raddr0 = (cmd.op == mse_pkg::OP_OUT_RD) ? k_r[IW-1:0] : i_r[IW-1:0];
  assign raddr1 = j_r[IW-1:0];

  assign we_a  = ((cmd.op == mse_pkg::OP_LOAD) && has_room) ||
                 ((cmd.op == mse_pkg::OP_WR) && src_b_r);
  assign we_b  = (cmd.op == mse_pkg::OP_WR) && !src_b_r;
  assign waddr = (cmd.op == mse_pkg::OP_LOAD) ? count_r[IW-1:0] : k_r[IW-1:0];
  assign wdata = (cmd.op == mse_pkg::OP_LOAD) ? in_value : merged;

  always_ff @(posedge clk) begin
    if (we_a) mem_a[waddr] <= wdata;
    if (re) begin
      a_rd0_r <= mem_a[raddr0];
      a_rd1_r <= mem_a[raddr1];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[waddr] <= wdata;
    if (re) begin
      b_rd0_r <= mem_b[raddr0];
      b_rd1_r <= mem_b[raddr1];
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    width_nxt = width_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    src_b_nxt = src_b_r;
    case (cmd.op)
      mse_pkg::OP_LOAD: begin
        if (has_room) begin
          count_nxt = count_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        width_nxt = CW'(1);
        lo_nxt    = '0;
        src_b_nxt = 1'b0;
      end
      mse_pkg::OP_RUN_INIT: begin
        mid_nxt = mid_clip;
        hi_nxt  = hi_clip;
        i_nxt   = lo_r;
        j_nxt   = mid_clip;
        k_nxt   = lo_r;
      end
      mse_pkg::OP_WR: begin
        k_nxt = k_r + CW'(1);
        if (take_left) begin
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      mse_pkg::OP_RUN_NEXT: begin
        lo_nxt = hi_r;
      end
      mse_pkg::OP_PASS_NEXT: begin
        width_nxt = {width_r[CW-2:0], 1'b0};
        lo_nxt    = '0;
        src_b_nxt = !src_b_r;
      end
      mse_pkg::OP_OUT_START: begin
        k_nxt = '0;
      end
      mse_pkg::OP_OUT_POP: begin
        k_nxt = k_r + CW'(1);
        if (status.out_last) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        k_nxt = k_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
    width_r <= width_nxt;
    lo_r    <= lo_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    src_b_r <= src_b_nxt;
  end

  assign status.pass_done = width_r >= count_r;
  assign status.run_done  = lo_r >= count_r;
  assign status.elem_done = k_r >= hi_r;
  assign status.out_last  = (k_r + CW'(1)) == count_r;

  assign out_value_res = left_v;
  assign out_last_res  = status.out_last;
  assign out_dropped   = ovf_r;

endmodule
`default_nettype wire

FILE: rtl/mse_checker.sv
// Checker: port-level properties of the merge sort engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mse_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        in_last,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire [mse_pkg::DATA_W-1:0]  out_value_res,
  input wire                        out_last_res,
  input wire                        out_dropped
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res) &&
    $stable(out_last_res) && $stable(out_dropped))
    else $error("result changed while stalled");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready during output");

  // closing a set stops loading, with no result shown yet
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready && !out_valid)
    else $error("set not closed by last");

  // after the final result the engine takes a new set
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_res |=> in_ready && !out_valid)
    else $error("engine did not reopen after final result");

  // within one set the drop flag cannot change between results
  a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_res |=> !in_ready && $stable(out_dropped))
    else $error("drop flag changed inside a set");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_last       (in_last),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_value_res (out_value_res),
  .out_last_res  (out_last_res),
  .out_dropped   (out_dropped)
);
`default_nettype wire
